// File: sv/ialu_pkg.sv
package ialu_pkg;

    localparam int unsigned NumRegsDefault = 7;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned KindWidth = 4;
    localparam int unsigned IndexWidth = 3;
    localparam int unsigned CountWidth = 6;

    localparam logic [KindWidth-1:0] KIND_MOV = 4'd0;
    localparam logic [KindWidth-1:0] KIND_XOR = 4'd1;
    localparam logic [KindWidth-1:0] KIND_CMP = 4'd2;
    localparam logic [KindWidth-1:0] KIND_RCL = 4'd3;
    localparam logic [KindWidth-1:0] KIND_SUB = 4'd4;
    localparam logic [KindWidth-1:0] KIND_SBB = 4'd5;
    localparam logic [KindWidth-1:0] KIND_AND = 4'd6;
    localparam logic [KindWidth-1:0] KIND_ADD = 4'd7;
    localparam logic [KindWidth-1:0] KIND_ADC = 4'd8;
    localparam logic [KindWidth-1:0] KIND_OR  = 4'd9;
    localparam logic [KindWidth-1:0] KIND_SHR = 4'd10;
    localparam logic [KindWidth-1:0] KIND_SAR = 4'd11;
    localparam logic [KindWidth-1:0] KIND_SHL = 4'd12;
    localparam logic [KindWidth-1:0] KIND_ROR = 4'd13;

    typedef struct packed {
        logic [KindWidth-1:0]  kind;
        logic [IndexWidth-1:0] dest_index;
        logic                  dest_in_memory;
        logic [DataWidth-1:0]  memory_word;
        logic                  source_from_reg;
        logic [IndexWidth-1:0] source_index;
        logic [DataWidth-1:0]  source_value;
        logic [CountWidth-1:0] shift_count;
    } t_in_item;

    typedef struct packed {
        logic [DataWidth-1:0] dest_result;
        logic                 memory_write;
        logic [DataWidth-1:0] memory_data;
        logic                 carry_out;
        logic                 zero_out;
        logic                 sign_out;
        logic                 unsupported;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic shifting;
        logic last_step;
    } t_status;

endpackage

// File: sv/ialu_if.sv
interface ialu_in_if
    import ialu_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ialu_out_if
    import ialu_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/ialu_ctrl.sv
module ialu_ctrl
    import ialu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.shifting) begin
                    n_state = ST_SHIFT;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                o_cmd.step = 1'b1;
                if (i_status.last_step) begin
                    n_state = ST_EXEC;
                end
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/ialu_datapath.sv
module ialu_datapath
    import ialu_pkg::*;
#(
    parameter int unsigned NUM_REGS = NumRegsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_item o_result
);

    localparam int unsigned Msb = DataWidth - 1;

    logic [DataWidth-1:0] r_regs [NUM_REGS];
    logic r_carry;
    logic r_zero;
    logic r_sign;

    t_in_item             r_item;
    logic [DataWidth-1:0] r_d;
    logic [DataWidth-1:0] r_src;
    logic                 r_bad;
    logic [CountWidth-1:0] r_cnt;
    logic                 r_shift_c;
    t_out_item            r_result;

    logic                 n_bad;
    logic                 uses_src;
    logic [DataWidth-1:0] n_src;
    logic [DataWidth-1:0] n_d;
    logic                 is_shift;
    logic [DataWidth-1:0] step_d;
    logic                 step_c;
    logic [DataWidth-1:0] fin_d;
    logic                 fin_c;
    logic                 fin_z;
    logic                 fin_s;

    always_comb begin
        uses_src = (i_item.kind <= KIND_OR) && (i_item.kind != KIND_RCL);
        n_bad = 1'b0;
        if (i_item.kind > KIND_ROR) n_bad = 1'b1;
        if (i_item.dest_in_memory && i_item.kind != KIND_MOV && i_item.kind != KIND_AND)
            n_bad = 1'b1;
        if (!i_item.dest_in_memory && 32'(i_item.dest_index) >= NUM_REGS) n_bad = 1'b1;
        if (i_item.kind == KIND_SBB && !i_item.source_from_reg) n_bad = 1'b1;
        if (uses_src && i_item.source_from_reg && 32'(i_item.source_index) >= NUM_REGS)
            n_bad = 1'b1;
        n_src = '0;
        if (uses_src) begin
            if (!i_item.source_from_reg) begin
                n_src = i_item.source_value;
            end else if (32'(i_item.source_index) < NUM_REGS) begin
                n_src = r_regs[i_item.source_index];
            end
        end
        n_d = '0;
        if (32'(i_item.dest_index) < NUM_REGS) n_d = r_regs[i_item.dest_index];
    end

    assign is_shift = !r_bad && !r_item.dest_in_memory && (r_item.kind == KIND_RCL
        || r_item.kind == KIND_SHR || r_item.kind == KIND_SAR
        || r_item.kind == KIND_SHL || r_item.kind == KIND_ROR);

    assign o_status.shifting = is_shift && (r_cnt != '0);
    assign o_status.last_step = (r_cnt == CountWidth'(1));

    // one bit per step
    always_comb begin
        step_d = r_d;
        step_c = r_shift_c;
        case (r_item.kind)
            KIND_RCL: begin
                step_d = {r_d[Msb-1:0], r_shift_c};
                step_c = r_d[Msb];
            end
            KIND_SHR: begin
                step_d = {1'b0, r_d[Msb:1]};
                step_c = r_d[0];
            end
            KIND_SAR: begin
                step_d = {r_d[Msb], r_d[Msb:1]};
                step_c = r_d[0];
            end
            KIND_SHL: begin
                step_d = {r_d[Msb-1:0], 1'b0};
                step_c = r_d[Msb];
            end
            KIND_ROR: step_d = {r_d[0], r_d[Msb:1]};
            default: ;
        endcase
    end

    always_comb begin
        fin_d = r_d;
        fin_c = r_carry;
        fin_z = r_zero;
        fin_s = r_sign;
        case (r_item.kind)
            KIND_MOV: fin_d = r_src;
            KIND_XOR: fin_d = r_d ^ r_src;
            KIND_CMP: begin
                if (r_d < r_src) begin
                    fin_c = 1'b1;
                    fin_z = 1'b0;
                    fin_s = 1'b1;
                end else begin
                    fin_c = 1'b0;
                    fin_z = (r_d == r_src);
                end
            end
            KIND_SUB: begin
                fin_c = (r_src > r_d);
                fin_d = r_d - r_src;
            end
            KIND_SBB: fin_d = r_d - (r_src + DataWidth'(r_carry));
            KIND_AND: fin_d = r_d & r_src;
            KIND_ADD: begin
                fin_d = r_d + r_src;
                fin_c = (fin_d < r_src);
            end
            KIND_ADC: begin
                fin_d = r_d + r_src + DataWidth'(r_carry);
                fin_c = (fin_d < r_src);
            end
            KIND_OR: fin_d = r_d | r_src;
            KIND_RCL, KIND_SHR, KIND_SAR, KIND_SHL: fin_c = r_shift_c;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_bad <= n_bad;
            r_src <= n_src;
            r_d <= n_d;
            r_cnt <= i_item.shift_count;
            r_shift_c <= r_carry;
        end else if (i_cmd.step) begin
            r_d <= step_d;
            r_shift_c <= step_c;
            r_cnt <= r_cnt - CountWidth'(1);
        end
        if (i_cmd.finish) begin
            r_result.dest_result <= '0;
            r_result.memory_write <= 1'b0;
            r_result.memory_data <= '0;
            r_result.unsupported <= r_bad;
            r_result.carry_out <= r_carry;
            r_result.zero_out <= r_zero;
            r_result.sign_out <= r_sign;
            if (!r_bad) begin
                if (r_item.dest_in_memory) begin
                    r_result.memory_write <= 1'b1;
                    r_result.memory_data <= (r_item.kind == KIND_MOV) ? r_src
                                          : (r_item.memory_word & r_src);
                end else begin
                    r_result.dest_result <= fin_d;
                    r_result.carry_out <= fin_c;
                    r_result.zero_out <= fin_z;
                    r_result.sign_out <= fin_s;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= '0;
            r_carry <= 1'b0;
            r_zero <= 1'b0;
            r_sign <= 1'b0;
        end else if (i_cmd.finish && !r_bad && !r_item.dest_in_memory) begin
            r_regs[r_item.dest_index] <= fin_d;
            r_carry <= fin_c;
            r_zero <= fin_z;
            r_sign <= fin_s;
        end
    end

    assign o_result = r_result;

endmodule

// File: sv/integer_alu_with_carry_flags.sv
// Executes one 32-bit integer instruction per input transaction against an internal
// register file and carry/zero/sign flags, returning one result transaction each.
// Non-shift kinds pass through EXEC to DONE, the result being registered as EXEC ends;
// rcl, shr, sar, shl and ror with a nonzero count also loop through SHIFT, where a
// single-bit shifter takes one counted bit (up to 63) per step. A new transaction is
// accepted in the cycle after the previous result has been taken, so none overlap.
module integer_alu_with_carry_flags
    import ialu_pkg::*;
#(
    parameter int unsigned NUM_REGS = NumRegsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ialu_in_if.sink    in_ch,
    ialu_out_if.source out_ch
);

    t_cmd    cmd;
    t_status status;

    ialu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ialu_datapath #(.NUM_REGS(NUM_REGS)) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch.data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (out_ch.data)
    );

endmodule
